@@ rtl/abc_pkg.sv @@
// Shared types, constants and codes for the allocation bitmap access check.
package abc_pkg;

  // Default map size in allocation units.
  localparam int NUM_UNITS_DEF = 4096;

  // Fixed byte address at which the heap begins.
  localparam logic [31:0] HEAP_BASE = 32'h0040_0000;

  // Field widths.
  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 25;
  localparam int START_W = 12;
  localparam int COUNT_W = 13;
  localparam int SHIFT_W = 4;
  localparam int HEAP_W  = 13;
  // Unit indexes that a request can reach stay below the heap size.
  localparam int UNIT_W  = 13;
  // Bits of a unit index that select a bit within a 32-bit map word.
  localparam int BIT_W   = 5;
  localparam int WORD_BITS = 32;

  // Stream and register port widths.
  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  // Register reset values.
  localparam logic [SHIFT_W-1:0] UNIT_SHIFT_RST = 4'd4;
  localparam logic [HEAP_W-1:0]  HEAP_UNITS_RST = 13'd4096;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Register indexes, taken from paddr[2].
  typedef enum logic {
    REG_UNIT_SHIFT = 1'b0,
    REG_HEAP_UNITS = 1'b1
  } reg_idx_e;

  // Request types as they arrive on the input stream.
  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_WRITE = 2'd3
  } req_type_e;

  // Result codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BOUNDS  = 2'd1,
    ST_UNALLOC = 2'd2
  } status_e;

  // Work kinds carried out by the back end.
  typedef enum logic [1:0] {
    K_SET = 2'd0,
    K_CLR = 2'd1,
    K_CHK = 2'd2
  } kind_e;

  // Front end states.
  typedef enum logic [1:0] {
    F_IDLE,
    F_CALC,
    F_PUSH
  } front_state_e;

  // Back end states.
  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_EVAL,
    B_DONE
  } back_state_e;

  // Configuration register contents.
  typedef struct packed {
    logic [SHIFT_W-1:0] unit_shift;
    logic [HEAP_W-1:0]  heap_units;
  } cfg_t;

  // One classified request waiting for the back end.
  typedef struct packed {
    kind_e             kind;
    logic              bad;
    logic              empty;
    logic [UNIT_W-1:0] first;
    logic [UNIT_W-1:0] last;
  } qent_t;

endpackage

@@ rtl/abc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module abc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/abc_fifo.sv @@
// Short request queue between the front and back ends.
module abc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  abc_pkg::qent_t entry_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output abc_pkg::qent_t head_o
);
  import abc_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  qent_t         slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push;
  logic          do_pop;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= entry_i;
    end
  end

endmodule

@@ rtl/abc_front.sv @@
// Front end: takes requests, checks bounds and turns them into unit ranges.
module abc_front #(
  parameter int NUM_UNITS = abc_pkg::NUM_UNITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  abc_pkg::cfg_t               cfg_i,
  input  logic                        hold_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  abc_pkg::req_type_e          in_type_i,
  input  logic [abc_pkg::ADDR_W-1:0]  in_addr_i,
  input  logic [abc_pkg::LEN_W-1:0]   in_len_i,
  input  logic [abc_pkg::START_W-1:0] in_start_i,
  input  logic [abc_pkg::COUNT_W-1:0] in_count_i,
  input  logic                        full_i,
  output logic                        push_o,
  output abc_pkg::qent_t              entry_o
);
  import abc_pkg::*;

  front_state_e       state_q, state_d;
  req_type_e          type_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [LEN_W-1:0]   len_q;
  logic [START_W-1:0] start_q;
  logic [COUNT_W-1:0] count_q;
  logic               bad_q, bad_d;
  logic               empty_q, empty_d;
  logic [ADDR_W-1:0]  lo_q, lo_d;
  logic [ADDR_W:0]    hi_q, hi_d;
  logic [HEAP_W-1:0]  heap_eff;
  logic [ADDR_W:0]    heap_lim;
  logic               is_mark;
  logic [COUNT_W:0]   mark_end;
  logic [ADDR_W:0]    chk_end;
  logic [ADDR_W-1:0]  chk_off;
  logic               accept;

  // Heap size in units is capped by the map size; the byte limit follows.
  assign heap_eff = (32'(cfg_i.heap_units) > NUM_UNITS) ? HEAP_W'(NUM_UNITS)
                                                        : cfg_i.heap_units;
  assign heap_lim = (ADDR_W + 1)'(HEAP_BASE)
                  + ((ADDR_W + 1)'(heap_eff) << cfg_i.unit_shift);

  assign is_mark  = (type_q == REQ_ALLOC) || (type_q == REQ_FREE);
  assign mark_end = (COUNT_W + 1)'(start_q) + (COUNT_W + 1)'(count_q);
  assign chk_end  = (ADDR_W + 1)'(addr_q) + (ADDR_W + 1)'(len_q);
  assign chk_off  = addr_q - HEAP_BASE;

  // Classification of the captured request.
  always_comb begin
    if (is_mark) begin
      bad_d   = mark_end > (COUNT_W + 1)'(heap_eff);
      empty_d = (count_q == '0);
      lo_d    = ADDR_W'(start_q);
      hi_d    = (ADDR_W + 1)'(mark_end) - 1'b1;
    end else begin
      bad_d   = (addr_q < HEAP_BASE) || (chk_end > heap_lim);
      empty_d = (len_q == '0);
      lo_d    = chk_off;
      hi_d    = (ADDR_W + 1)'(chk_off) + (ADDR_W + 1)'(len_q) - 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (in_valid_i && !hold_i) state_d = F_CALC;
      F_CALC: state_d = F_PUSH;
      F_PUSH: if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    unique case (state_q)
      F_IDLE: in_ready_o = !hold_i;
      F_CALC: ;
      F_PUSH: push_o = !full_i;
      default: ;
    endcase
  end

  // Queue entry: checks turn byte offsets into unit indexes here.
  always_comb begin
    unique case (type_q)
      REQ_ALLOC: entry_o.kind = K_SET;
      REQ_FREE:  entry_o.kind = K_CLR;
      REQ_READ,
      REQ_WRITE: entry_o.kind = K_CHK;
      default:   entry_o.kind = K_CHK;
    endcase
    entry_o.bad   = bad_q;
    entry_o.empty = empty_q;
    if (is_mark) begin
      entry_o.first = UNIT_W'(lo_q);
      entry_o.last  = UNIT_W'(hi_q);
    end else begin
      entry_o.first = UNIT_W'(lo_q >> cfg_i.unit_shift);
      entry_o.last  = UNIT_W'(hi_q >> cfg_i.unit_shift);
    end
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Request capture and classification registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      type_q  <= in_type_i;
      addr_q  <= in_addr_i;
      len_q   <= in_len_i;
      start_q <= in_start_i;
      count_q <= in_count_i;
    end
    if (state_q == F_CALC) begin
      bad_q   <= bad_d;
      empty_q <= empty_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
    end
  end

endmodule

@@ rtl/abc_back.sv @@
// Back end: clears the map after reset, then walks map words per request.
module abc_back #(
  parameter int NUM_UNITS = abc_pkg::NUM_UNITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  output logic                            clearing_o,
  input  logic                            empty_i,
  input  abc_pkg::qent_t                  head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output abc_pkg::status_e                out_status_o
);
  import abc_pkg::*;

  localparam int MAP_WORDS = (NUM_UNITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  back_state_e          state_q, state_d;
  qent_t                ent_q;
  logic [WW-1:0]        word_q;
  logic [WW-1:0]        clr_q;
  status_e              status_q;
  logic                 out_valid_q;
  status_e              out_status_q;
  logic [WW-1:0]        first_word;
  logic [WW-1:0]        last_word;
  logic [WW-1:0]        head_first_word;
  logic [BIT_W-1:0]     lo_bit;
  logic [BIT_W-1:0]     hi_bit;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] rdata;
  logic                 miss;
  logic                 at_last;
  logic                 out_free;
  logic                 ram_we;
  logic [WW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;

  abc_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(word_q),
    .rdata_o(rdata)
  );

  // Word range and bit mask of the current word.
  assign first_word      = WW'(ent_q.first >> BIT_W);
  assign last_word       = WW'(ent_q.last >> BIT_W);
  assign head_first_word = WW'(head_i.first >> BIT_W);
  assign lo_bit  = (word_q == first_word) ? ent_q.first[BIT_W-1:0] : '0;
  assign hi_bit  = (word_q == last_word) ? ent_q.last[BIT_W-1:0] : '1;
  assign mask    = ({WORD_BITS{1'b1}} << lo_bit)
                 & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_bit));
  assign miss    = (rdata & mask) != mask;
  assign at_last = (word_q == last_word);
  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_CLEAR: if (clr_q == WW'(MAP_WORDS - 1)) state_d = B_IDLE;
      B_IDLE: begin
        if (!empty_i) begin
          state_d = (head_i.bad || head_i.empty) ? B_DONE : B_READ;
        end
      end
      B_READ: state_d = B_EVAL;
      B_EVAL: begin
        if ((ent_q.kind == K_CHK && miss) || at_last) begin
          state_d = B_DONE;
        end else begin
          state_d = B_READ;
        end
      end
      B_DONE: if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // Outputs toward the queue and the map memory.
  always_comb begin
    clearing_o = 1'b0;
    pop_o      = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = word_q;
    ram_wdata  = rdata | mask;
    ram_re     = 1'b0;
    unique case (state_q)
      B_CLEAR: begin
        clearing_o = 1'b1;
        ram_we     = 1'b1;
        ram_waddr  = clr_q;
        ram_wdata  = '0;
      end
      B_IDLE: pop_o = !empty_i;
      B_READ: ram_re = 1'b1;
      B_EVAL: begin
        ram_we    = (ent_q.kind == K_SET) || (ent_q.kind == K_CLR);
        ram_wdata = (ent_q.kind == K_SET) ? (rdata | mask) : (rdata & ~mask);
      end
      B_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      // Result register: loaded when done, emptied when taken.
      if (state_q == B_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request, word walk and status registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        ent_q    <= head_i;
        word_q   <= head_first_word;
        status_q <= head_i.bad ? ST_BOUNDS : ST_OK;
      end
      B_EVAL: begin
        if (ent_q.kind == K_CHK && miss) begin
          status_q <= ST_UNALLOC;
        end
        word_q <= word_q + 1'b1;
      end
      B_DONE: begin
        if (out_free) begin
          out_status_q <= status_q;
        end
      end
      B_CLEAR, B_READ: ;
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;

endmodule

@@ rtl/allocation_bitmap_access_check.sv @@
// Top level of the allocation bitmap access check.
//
//  Channel   Direction  Content
//  s_axis    in         tdata: address, length, start_unit, unit_count; tuser: req_type
//  m_axis    out        tdata: status
//  apb       in         registers unit_shift (0x0) and heap_units (0x4)
//
// A request passes the front end states F_IDLE, F_CALC and F_PUSH. In the back end
// each 32-bit map word that its unit range spans takes a map read state and an
// evaluate state, in which a mark writes the word back. A check stops after the
// first word that holds an unallocated unit. Requests that fail the bounds check
// or have zero length or count go straight to the done state in the back end.
// After reset the map is cleared one word a cycle, while s_axis_tready stays low.
// A stalled result holds in the output register while the front end keeps taking
// requests into a 2-entry queue.
module allocation_bitmap_access_check #(
  parameter int NUM_UNITS = abc_pkg::NUM_UNITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [31:0] address, [56:32] length, [68:57] start_unit, [81:69] unit_count
  input  logic [abc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [abc_pkg::IN_TUSER_W-1:0] s_axis_tuser,
  // Result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [1:0] status
  output logic [abc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // Register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [abc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [abc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [abc_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import abc_pkg::*;

  localparam int LEN_LO   = ADDR_W;
  localparam int START_LO = LEN_LO + LEN_W;
  localparam int COUNT_LO = START_LO + START_W;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_we;
  logic     clearing;
  logic     full;
  logic     push;
  qent_t    entry;
  logic     empty;
  logic     pop;
  qent_t    head;
  status_e  out_status;

  // Register port: always ready, written in the access phase.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      REG_UNIT_SHIFT: prdata = APB_DATA_W'(cfg_q.unit_shift);
      REG_HEAP_UNITS: prdata = APB_DATA_W'(cfg_q.heap_units);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.unit_shift <= UNIT_SHIFT_RST;
      cfg_q.heap_units <= HEAP_UNITS_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_UNIT_SHIFT: cfg_q.unit_shift <= pwdata[SHIFT_W-1:0];
        REG_HEAP_UNITS: cfg_q.heap_units <= pwdata[HEAP_W-1:0];
        default: ;
      endcase
    end
  end

  abc_front #(
    .NUM_UNITS(NUM_UNITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .hold_i    (clearing),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_type_i (req_type_e'(s_axis_tuser[1:0])),
    .in_addr_i (s_axis_tdata[ADDR_W-1:0]),
    .in_len_i  (s_axis_tdata[LEN_LO +: LEN_W]),
    .in_start_i(s_axis_tdata[START_LO +: START_W]),
    .in_count_i(s_axis_tdata[COUNT_LO +: COUNT_W]),
    .full_i    (full),
    .push_o    (push),
    .entry_o   (entry)
  );

  abc_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .head_o (head)
  );

  abc_back #(
    .NUM_UNITS(NUM_UNITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clearing_o  (clearing),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_status_o(out_status)
  );

  assign m_axis_tdata = OUT_TDATA_W'(out_status);

endmodule

@@ rtl/abc_checker.sv @@
// Port-level checker for the allocation bitmap access check, bound to the top.
module abc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [abc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input logic [abc_pkg::IN_TUSER_W-1:0] s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [abc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [abc_pkg::APB_ADDR_W-1:0] paddr,
  input logic [abc_pkg::APB_DATA_W-1:0] pwdata,
  input logic [abc_pkg::APB_DATA_W-1:0] prdata,
  input logic                           pready
);
  import abc_pkg::*;

  logic in_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;

  // The front end does not take a request while it works on the one before.
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input taken on the cycle after a request");

  // A result carries one of the defined status codes.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata == OUT_TDATA_W'(ST_OK)
                   || m_axis_tdata == OUT_TDATA_W'(ST_BOUNDS)
                   || m_axis_tdata == OUT_TDATA_W'(ST_UNALLOC)))
    else $error("undefined status code");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // A unit size written is read back on the next cycle.
  a_shift_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && !paddr[2])
      ##1 (psel && !pwrite && !paddr[2])
      |-> prdata[SHIFT_W-1:0] == $past(pwdata[SHIFT_W-1:0]))
    else $error("unit_shift readback mismatch");

  // Register reads return zeros above the widest register.
  a_prdata_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && !pwrite) |-> prdata[APB_DATA_W-1:HEAP_W] == '0)
    else $error("register read carries nonzero upper bits");

endmodule

bind allocation_bitmap_access_check abc_checker u_abc_checker (.*);
